// ===== design/sha256h_pkg.sv =====
// Shared types and constants for the SHA-256 hasher.
// Holds the round constants, initial hash values and the controller/datapath
// command and status structs. No dependencies.
package sha256h_pkg;

  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned ROUNDS     = 64;

  localparam logic [31:0] INIT_H [0:HASH_WORDS-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ABSORB,
    OP_PAD,
    OP_ZERO,
    OP_LEN_HI,
    OP_LEN_LO,
    OP_ROUND,
    OP_UPDATE,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic fill_next;
    logic wcnt14;
    logic wcnt15;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/sha256h_if.sv =====
// Valid/ready channel interfaces for the SHA-256 hasher.
// Message words in, digest words out. No dependencies.
interface sha256h_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [5:0]  valid_bits;
  logic        final_req;

  modport source (output valid, output data_word, output valid_bits, output final_req,
                  input ready);
  modport sink   (input valid, input data_word, input valid_bits, input final_req,
                  output ready);
endinterface

interface sha256h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== design/sha256h_dp.sv =====
// Datapath: bit packer, 16-word schedule shift line, round logic, hash state
// and digest output register. Driven by sha256h_ctrl; uses sha256h_pkg.
module sha256h_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sha256h_pkg::cmd_t   cmd,
  output sha256h_pkg::stat_t  stat,
  input  logic [31:0]         in_data,
  input  logic [5:0]          in_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_digest,
  output logic [2:0]          out_index,
  output logic                out_last
);
  import sha256h_pkg::*;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [31:0] w_r    [BLK_WORDS];
  logic [31:0] hash_r [HASH_WORDS];
  logic [31:0] v_r    [HASH_WORDS];
  logic [31:0] dig_r  [HASH_WORDS];
  logic [31:0] partial_r;
  logic [4:0]  pfill_r;
  logic [4:0]  wcnt_r;
  logic [63:0] len_r;
  logic        busy_r;
  logic [2:0]  idx_r;

  logic [5:0]  nv;
  logic [31:0] dmask;
  logic [63:0] packed64;
  logic [6:0]  bit_sum;
  logic        word_full;
  logic        push_en;
  logic [31:0] push_word;
  logic [31:0] sched_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic        out_hs;

  assign nv        = (in_bits > 6'd32) ? 6'd32 : in_bits;
  assign dmask     = in_data & ~(32'hffff_ffff >> nv);
  assign packed64  = {partial_r, 32'd0} | ({dmask, 32'd0} >> pfill_r);
  assign bit_sum   = {2'b00, pfill_r} + {1'b0, nv};
  assign word_full = (bit_sum[6:5] != 2'b00);

  assign sched_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign ch        = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj       = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1        = v_r[7] + bsig1(v_r[4]) + ch + ROUND_K[cmd.rnd] + w_r[0];
  assign t2        = bsig0(v_r[0]) + maj;

  always_comb begin
    push_en   = 1'b0;
    push_word = 32'd0;
    case (cmd.op)
      OP_ABSORB: begin
        push_en   = word_full;
        push_word = packed64[63:32];
      end
      OP_PAD: begin
        push_en   = 1'b1;
        push_word = partial_r | (32'h8000_0000 >> pfill_r);
      end
      OP_ZERO: begin
        push_en   = 1'b1;
        push_word = 32'd0;
      end
      OP_LEN_HI: begin
        push_en   = 1'b1;
        push_word = len_r[63:32];
      end
      OP_LEN_LO: begin
        push_en   = 1'b1;
        push_word = len_r[31:0];
      end
      default: begin
        push_en   = 1'b0;
        push_word = 32'd0;
      end
    endcase
  end

  assign out_hs = busy_r & out_ready;

  // schedule shift line and digest shift register: no reset
  always_ff @(posedge clk) begin
    if (push_en) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BLK_WORDS-1] <= push_word;
    end else if (cmd.op == OP_ROUND) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BLK_WORDS-1] <= sched_new;
    end
    if (cmd.op == OP_FINISH) begin
      for (int i = 0; i < HASH_WORDS; i++) dig_r[i] <= hash_r[i];
    end else if (out_hs) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) dig_r[i] <= dig_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        hash_r[i] <= INIT_H[i];
        v_r[i]    <= INIT_H[i];
      end
      partial_r <= 32'd0;
      pfill_r   <= 5'd0;
      wcnt_r    <= 5'd0;
      len_r     <= 64'd0;
      busy_r    <= 1'b0;
      idx_r     <= 3'd0;
    end else begin
      if (push_en) wcnt_r <= wcnt_r + 5'd1;
      if (out_hs) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'(HASH_WORDS - 1)) busy_r <= 1'b0;
      end
      case (cmd.op)
        OP_ABSORB: begin
          len_r <= len_r + {58'd0, nv};
          if (word_full) begin
            partial_r <= packed64[31:0];
            pfill_r   <= bit_sum[4:0];
          end else begin
            partial_r <= packed64[63:32];
            pfill_r   <= bit_sum[4:0];
          end
        end
        OP_PAD: begin
          partial_r <= 32'd0;
          pfill_r   <= 5'd0;
        end
        OP_ROUND: begin
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
        end
        OP_UPDATE: begin
          // working vars restart from the new hash for the next block
          for (int i = 0; i < HASH_WORDS; i++) begin
            hash_r[i] <= hash_r[i] + v_r[i];
            v_r[i]    <= hash_r[i] + v_r[i];
          end
          wcnt_r <= 5'd0;
        end
        OP_FINISH: begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            hash_r[i] <= INIT_H[i];
            v_r[i]    <= INIT_H[i];
          end
          len_r  <= 64'd0;
          busy_r <= 1'b1;
          idx_r  <= 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.fill_next = word_full && (wcnt_r == 5'(BLK_WORDS - 1));
  assign stat.wcnt14    = (wcnt_r == 5'(BLK_WORDS - 2));
  assign stat.wcnt15    = (wcnt_r == 5'(BLK_WORDS - 1));
  assign stat.out_busy  = busy_r;

  assign out_valid  = busy_r;
  assign out_digest = dig_r[0];
  assign out_index  = idx_r;
  assign out_last   = (idx_r == 3'(HASH_WORDS - 1));

endmodule

// ===== design/sha256h_ctrl.sv =====
// Controller: sequences absorb, padding, length words, the 64 rounds, hash
// update and digest hand-off. Commands sha256h_dp; uses sha256h_pkg.
module sha256h_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_final,
  input  sha256h_pkg::stat_t  stat,
  output sha256h_pkg::cmd_t   cmd
);
  import sha256h_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_PADZ,
    S_LEN,
    S_ROUND,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       fin_r, fin_nxt;
  logic       padph_r, padph_nxt;
  logic       lastb_r, lastb_nxt;
  logic       in_ready_r;

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    fin_nxt   = fin_r;
    padph_nxt = padph_r;
    lastb_nxt = lastb_r;
    cmd.op    = OP_NONE;
    cmd.rnd   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.op    = OP_ABSORB;
          fin_nxt   = in_final;
          padph_nxt = 1'b0;
          lastb_nxt = 1'b0;
          rnd_nxt   = 6'd0;
          if (stat.fill_next)  state_nxt = S_ROUND;
          else if (in_final)   state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.op    = OP_PAD;
        padph_nxt = 1'b1;
        state_nxt = stat.wcnt15 ? S_ROUND : S_PADZ;
      end
      S_PADZ: begin
        if (stat.wcnt14) begin
          cmd.op    = OP_LEN_HI;
          state_nxt = S_LEN;
        end else begin
          cmd.op    = OP_ZERO;
          if (stat.wcnt15) state_nxt = S_ROUND;
        end
      end
      S_LEN: begin
        cmd.op    = OP_LEN_LO;
        lastb_nxt = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op  = OP_ROUND;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.op = OP_UPDATE;
        if (lastb_r)      state_nxt = S_DONE;
        else if (padph_r) state_nxt = S_PADZ;
        else if (fin_r)   state_nxt = S_PAD;
        else              state_nxt = S_IDLE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_FINISH;
          fin_nxt   = 1'b0;
          padph_nxt = 1'b0;
          lastb_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rnd_r      <= 6'd0;
      fin_r      <= 1'b0;
      padph_r    <= 1'b0;
      lastb_r    <= 1'b0;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      fin_r      <= fin_nxt;
      padph_r    <= padph_nxt;
      lastb_r    <= lastb_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== design/sha256_hasher.sv =====
// SHA-256 hasher top level: joins sha256h_ctrl and sha256h_dp.
// Depends on sha256h_pkg and the channel interfaces in sha256h_if.
//
// Usage: message words arrive on in_ch, MSB first, each with a count of
// leading valid bits (values above 32 count as 32) and final_req on the last
// word. Words shorter than 32 bits are packed at bit granularity. The eight
// digest words leave on out_ch, H0 first, last_word set on H7.
// A word that does not complete a 512-bit block leaves the input ready for the
// next word. A word that completes a block starts a compression: 64 rounds at
// one round per cycle through the single round unit, then a hash update.
// A final word then adds padding, zero and length words (up to 18) and one or
// two further compressions before the digest is loaded into the output
// register.
// The digest sits in its own shift register, so a new message is taken while
// digest words are still being read; the next digest waits for that register
// to empty. A stall on out_ch holds the current digest word.
// Reset (synchronous, active low) restores the initial hash, clears the
// length and fill and drops both valid and ready.
module sha256_hasher (
  input logic          clk,
  input logic          rst_n,
  sha256h_in_if.sink   in_ch,
  sha256h_out_if.source out_ch
);
  import sha256h_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha256h_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_final (in_ch.final_req),
    .stat     (stat),
    .cmd      (cmd)
  );

  sha256h_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_ch.data_word),
    .in_bits    (in_ch.valid_bits),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_digest (out_ch.digest_word),
    .out_index  (out_ch.word_index),
    .out_last   (out_ch.last_word)
  );

endmodule

// ===== design/sha256h_chk.sv =====
// Port-level checks for sha256_hasher, attached by bind.
// Sees only the top level's channel signals; no package dependency.
module sha256h_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_index,
  input logic       out_last
);

  // digest words come out in order without gaps
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_index == $past(out_index) + 3'd1))
    else $error("digest word index did not advance");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_index == 3'd0))
    else $error("digest did not start at H0");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_index == 3'd7)))
    else $error("last word flag out of step with index");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final) |=> !in_ready)
    else $error("input taken during padding");

  a_end_of_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("digest word repeated after last word");

endmodule

bind sha256_hasher sha256h_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_final  (in_ch.final_req),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.word_index),
  .out_last  (out_ch.last_word)
);

// ===== verif/tb_sha256_hasher.sv =====
// Self-checking testbench for sha256_hasher: directed and random messages
// at bit granularity, each digest word checked against an in-bench SHA-256 model.
// Depends on sha256h_pkg and the channel interfaces in sha256h_if.
module tb_sha256_hasher;
  import sha256h_pkg::*;

  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned OUT_HOLD   = 700;
  localparam int unsigned TAIL_WAIT  = 200;
  localparam int unsigned N_ITEMS    = 450;

  typedef struct {
    logic [31:0] digest;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic clk;
  logic rst_n;

  sha256h_in_if  in_ch ();
  sha256h_out_if out_ch ();

  sha256_hasher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // model state
  logic [31:0] hash_h [8];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [63:0] msg_len;

  digest_exp_t digest_q [$];
  digest_exp_t want;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          hold_out_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_init();
    for (int i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
    fill    = 0;
    msg_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
    e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endfunction

  function automatic void put_bit(input logic bitv);
    int unsigned idx;
    idx = (fill >> 5) & 15;
    if ((fill & 31) == 0) blk[idx] = '0;
    blk[idx][31 - (fill & 31)] = bitv;
    fill++;
  endfunction

  // absorb one accepted word; on a final word, pad and queue the digest
  function automatic void absorb_word(input logic [31:0] data, input logic [5:0] nv,
                                      input logic fin);
    int unsigned n;
    digest_exp_t d;
    n = (nv > 32) ? 32 : nv;
    for (int i = 0; i < n; i++) begin
      put_bit(data[31 - i]);
      if (fill >= 512) begin
        sha_compress();
        fill = 0;
      end
    end
    msg_len += 64'(n);
    if (fin) begin
      put_bit(1'b1);
      while ((fill & 31) != 0) put_bit(1'b0);
      if (fill > 448) begin
        while (fill < 512) begin
          blk[(fill >> 5) & 15] = '0;
          fill += 32;
        end
        sha_compress();
        fill = 0;
      end
      while (fill < 448) begin
        blk[(fill >> 5) & 15] = '0;
        fill += 32;
      end
      blk[14] = msg_len[63:32];
      blk[15] = msg_len[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        d.digest = hash_h[i];
        d.idx    = 3'(i);
        d.last   = (i == 7);
        digest_q.push_back(d);
      end
      hash_init();
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_word(input logic [31:0] data, input logic [5:0] nv, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_word  <= data;
    in_ch.valid_bits <= nv;
    in_ch.final_req  <= fin;
    do @(posedge clk); while (!in_ch.ready);
    absorb_word(data, nv, fin);
    items_sent++;
  endtask

  task automatic wait_digests_done();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or one long hold when asked
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_out_req) begin
        out_ch.ready <= 1'b0;
        repeat (OUT_HOLD) @(negedge clk);
        hold_out_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                 $time, out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        err_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (out_ch.digest_word !== want.digest) begin
          $display("%0t: digest_word mismatch: expected %h, actual %h",
                   $time, want.digest, out_ch.digest_word);
          err_cnt++;
        end
        if (out_ch.word_index !== want.idx) begin
          $display("%0t: word_index mismatch: expected %0d, actual %0d",
                   $time, want.idx, out_ch.word_index);
          err_cnt++;
        end
        if (out_ch.last_word !== want.last) begin
          $display("%0t: last_word mismatch: expected %0b, actual %0b",
                   $time, want.last, out_ch.last_word);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("sha256_hasher verification failed");
      $finish;
    end
  end

  task automatic test_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_empty_message();
    send_word($urandom, 6'd0, 1'b1);
  endtask

  task automatic test_full_word_messages();
    send_word(32'hffffffff, 6'd32, 1'b1);
    send_word(32'h00000000, 6'd32, 1'b1);
  endtask

  task automatic test_oversized_count();
    send_word($urandom, 6'd63, 1'b1);
    send_word($urandom, 6'd33, 1'b0);
    send_word($urandom, 6'd40, 1'b1);
  endtask

  task automatic test_unaligned_words();
    send_word($urandom, 6'd1, 1'b0);
    send_word($urandom, 6'd0, 1'b0);
    send_word($urandom, 6'd31, 1'b1);
  endtask

  // 448 message bits: padding spills into a second block
  task automatic test_two_block_padding();
    for (int i = 0; i < 14; i++) send_word($urandom, 6'd32, 1'b0);
    send_word($urandom, 6'd0, 1'b1);
  endtask

  task automatic test_output_hold();
    no_idle      = 1'b1;
    hold_out_req = 1'b1;
    for (int i = 0; i < 6; i++) send_word($urandom, 6'($urandom_range(0, 32)), 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_digests_done();
    send_word($urandom, 6'd32, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned r, len;
    logic [5:0] nv;
    while (items_sent < N_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 17);
      else if (r < 92) len = $urandom_range(18, 40);
      else len = 0;
      no_idle = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        nv = ($urandom_range(0, 99) < 85) ? 6'd32 : 6'($urandom_range(0, 63));
        send_word($urandom, nv, 1'b0);
      end
      nv = ($urandom_range(0, 1) == 0) ? 6'd32 : 6'($urandom_range(0, 63));
      send_word($urandom, nv, 1'b1);
      if ($urandom_range(0, 19) == 0) wait_digests_done();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_word  = '0;
    in_ch.valid_bits = '0;
    in_ch.final_req  = 1'b0;
    out_ch.ready     = 1'b0;
    err_cnt          = 0;
    items_sent       = 0;
    idle_cycles      = 0;
    no_idle          = 1'b0;
    hold_out_req     = 1'b0;
    hash_init();

    test_reset();
    test_empty_message();
    test_full_word_messages();
    test_oversized_count();
    test_unaligned_words();
    test_two_block_padding();
    test_output_hold();
    test_drain_pause();
    test_random_messages();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_digests_done();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_cnt == 0) $display("sha256_hasher verification clean");
    else $display("sha256_hasher verification failed");
    $finish;
  end

endmodule
